/* design/threshold_alarm_monitor_macros.svh */
// ----------------------------------------------------------------------------
// Threshold alarm monitor assertion macros
// Concurrent assertion wrappers shared by the monitor's modules.
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_ALARM_MONITOR_MACROS_SVH
`define THRESHOLD_ALARM_MONITOR_MACROS_SVH

`ifndef ASSERT_OFF

`define TAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define TAM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TAM_ASSERT(lbl, prop, msg)

`define TAM_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* design/tam_pkg.sv */
// ----------------------------------------------------------------------------
// Threshold alarm monitor package
// Item types and fixed constants shared by the monitor's modules.
// ----------------------------------------------------------------------------
package tam_pkg;

  localparam int NumSlots = 8;
  localparam int RuleIdxW = 3;
  localparam int RuleW    = 43;
  localparam int QDepth   = 4;
  localparam int QPtrW    = 2;

  typedef struct packed {
    logic [31:0] threshold;
    logic [1:0]  severity;
    logic [7:0]  rtype;
    logic        valid;
  } rule_t;

  typedef struct packed {
    logic [7:0]  metric_type;
    logic [31:0] sample_milli;
    logic [47:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic [2:0]  rule_index;
    logic [7:0]  fired_type;
    logic [1:0]  fired_severity;
    logic [47:0] fire_time_ms;
    logic [31:0] value_milli;
    logic [31:0] limit_milli;
    logic        last_alarm;
  } alarm_t;

endpackage

/* design/tam_front.sv */
// ----------------------------------------------------------------------------
// Threshold alarm monitor front end
// Accepts a sample and walks the rules one per cycle unless stalled, keeping
// hold-off and hysteresis state, and queues one item per fired rule.
// ----------------------------------------------------------------------------
`include "threshold_alarm_monitor_macros.svh"

module tam_front #(
  parameter int NUM_RULES  = 8,
  parameter int HOLDOFF_MS = 10000
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  tam_pkg::sample_t                            in_data,
  input  tam_pkg::rule_t [tam_pkg::NumSlots-1:0]      rules,
  output logic                                        q_push,
  output tam_pkg::alarm_t                             q_data,
  input  logic                                        q_full
);
  import tam_pkg::*;

  localparam int IdxW = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam logic [RuleIdxW-1:0] LastRule = RuleIdxW'(NUM_RULES - 1);
  localparam logic [47:0] Holdoff = 48'(HOLDOFF_MS);

  logic                busy_r;
  logic [RuleIdxW-1:0] scan_r;
  sample_t             smp_r;
  logic [35:0]         val10_r;
  logic                pend_vld_r;
  alarm_t              pend_r;
  logic [47:0]         last_time_r [NUM_RULES];
  logic                active_r [NUM_RULES];

  rule_t               cur;
  logic [IdxW-1:0]     idx;
  logic                match;
  logic                reach;
  logic [47:0]         elapsed;
  logic                held;
  logic                fire;
  logic [35:0]         thr9;
  logic                clear;
  logic                stall;
  logic                step;
  logic                flush;
  logic                accept;
  alarm_t              new_rec;

  always_comb begin
    cur     = rules[scan_r];
    idx     = scan_r[IdxW-1:0];
    match   = cur.valid && (cur.rtype == smp_r.metric_type);
    reach   = smp_r.sample_milli >= cur.threshold;
    elapsed = smp_r.now_ms - last_time_r[idx];
    held    = (last_time_r[idx] != '0) && (elapsed < Holdoff);
    fire    = busy_r && match && reach && !held;
    thr9    = 36'({cur.threshold, 3'b000}) + 36'(cur.threshold);
    clear   = busy_r && match && !reach && active_r[idx] && (val10_r < thr9);
    stall   = fire && pend_vld_r && q_full;
    step    = busy_r && !stall;
    flush   = !busy_r && pend_vld_r && !q_full;
    q_push  = (fire && pend_vld_r && !q_full) || flush;
    q_data  = pend_r;
    q_data.last_alarm = !busy_r;

    new_rec.rule_index     = scan_r;
    new_rec.fired_type     = cur.rtype;
    new_rec.fired_severity = cur.severity;
    new_rec.fire_time_ms   = smp_r.now_ms;
    new_rec.value_milli    = smp_r.sample_milli;
    new_rec.limit_milli    = cur.threshold;
    new_rec.last_alarm     = 1'b0;
  end

  assign in_ready = !busy_r && !pend_vld_r;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      scan_r     <= '0;
      pend_vld_r <= 1'b0;
      for (int i = 0; i < NUM_RULES; i++) begin
        last_time_r[i] <= '0;
        active_r[i]    <= 1'b0;
      end
    end else if (accept) begin
      busy_r <= 1'b1;
      scan_r <= '0;
    end else if (step) begin
      if (scan_r == LastRule) begin
        busy_r <= 1'b0;
      end else begin
        scan_r <= scan_r + 1'b1;
      end
      if (fire) begin
        last_time_r[idx] <= smp_r.now_ms;
        active_r[idx]    <= 1'b1;
        pend_vld_r       <= 1'b1;
      end else if (clear) begin
        active_r[idx] <= 1'b0;
      end
    end else if (flush) begin
      pend_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp_r   <= in_data;
      val10_r <= 36'({in_data.sample_milli, 3'b000}) + 36'({in_data.sample_milli, 1'b0});
    end
    if (step && fire) begin
      pend_r <= new_rec;
    end
  end

  `TAM_ASSERT(a_accept_starts_scan, accept |=> busy_r && scan_r == '0, "scan did not start")
  `TAM_ASSERT(a_scan_in_range, busy_r |-> scan_r <= LastRule, "scan beyond last rule")
  `TAM_ASSERT(a_no_accept_pending, pend_vld_r |-> !in_ready, "item taken with alarm held")

endmodule

/* design/tam_queue.sv */
// ----------------------------------------------------------------------------
// Threshold alarm monitor alarm queue
// Short first-in first-out buffer between the rule walk and the output stage.
// ----------------------------------------------------------------------------
`include "threshold_alarm_monitor_macros.svh"

module tam_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tam_pkg::alarm_t push_data,
  output logic            full,
  output logic            q_valid,
  output tam_pkg::alarm_t q_data,
  input  logic            pop
);
  import tam_pkg::*;

  alarm_t             mem_r [QDepth];
  logic [QPtrW-1:0]   wr_ptr_r;
  logic [QPtrW-1:0]   rd_ptr_r;
  logic [QPtrW:0]     cnt_r;

  assign full    = cnt_r == (QPtrW + 1)'(QDepth);
  assign q_valid = cnt_r != '0;
  assign q_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `TAM_ASSERT(a_no_overflow, push |-> !full, "push into full queue")
  `TAM_ASSERT(a_no_underflow, pop |-> q_valid, "pop from empty queue")
  `TAM_ASSERT(a_count_bound, cnt_r <= (QPtrW + 1)'(QDepth), "queue count too large")

endmodule

/* design/tam_back.sv */
// ----------------------------------------------------------------------------
// Threshold alarm monitor output stage
// Registers queued alarms onto the result channel.
// ----------------------------------------------------------------------------
module tam_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  tam_pkg::alarm_t q_data,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output tam_pkg::alarm_t out_data
);
  import tam_pkg::*;

  logic   out_valid_r;
  alarm_t out_data_r;

  assign pop       = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= q_data;
    end
  end

endmodule

/* design/threshold_alarm_monitor.sv */
// ----------------------------------------------------------------------------
// Threshold alarm monitor
// Checks metric samples against up to eight threshold rules with hold-off
// and hysteresis, and reports one item per rule that fires.
// ----------------------------------------------------------------------------
// A sample is checked against rules 0 to NUM_RULES-1, one rule per cycle,
// starting in the cycle after it is accepted. When no rule fires the input is
// ready again once the walk ends; when any rule fires, the final alarm, marked
// last_alarm, is then handed to the queue once it is not full, and only then
// is the input ready again. The walk stalls only when a rule fires while an
// alarm is held and the four-item alarm queue is full. Alarms leave through a
// registered output at up to one item per cycle while out_ready is high.
// Rules are to be written through the cfg port only while the block is idle;
// the block itself does not enforce this.
module threshold_alarm_monitor #(
  parameter int NUM_RULES  = 8,
  parameter int HOLDOFF_MS = 10000
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tam_pkg::sample_t       in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tam_pkg::alarm_t        out_data,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [42:0]            cfg_data
);
  import tam_pkg::*;

  rule_t [NumSlots-1:0] rules_r;
  logic                 q_push;
  alarm_t               q_push_data;
  logic                 q_full;
  logic                 q_valid;
  alarm_t               q_data;
  logic                 q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rules_r <= '0;
    end else if (cfg_we) begin
      rules_r[cfg_index] <= rule_t'(cfg_data);
    end
  end

  tam_front #(
    .NUM_RULES  (NUM_RULES),
    .HOLDOFF_MS (HOLDOFF_MS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .rules    (rules_r),
    .q_push   (q_push),
    .q_data   (q_push_data),
    .q_full   (q_full)
  );

  tam_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (q_pop)
  );

  tam_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* test/threshold_alarm_monitor_tb.sv */
// ----------------------------------------------------------------------------
// Threshold alarm monitor testbench
// Drives metric samples through the valid/ready input and loads rule sets
// through the write port while the block is idle. Each accepted sample is run
// through a behavioural copy of the rule walk, with its own hold-off and
// hysteresis state, and every alarm item leaving the block is compared field
// by field with the oldest alarm still outstanding. A short table of directed
// samples comes first, followed by random phases under fresh rule sets.
// ----------------------------------------------------------------------------
module threshold_alarm_monitor_tb;
  import tam_pkg::*;

  localparam int NumRules      = 8;
  localparam int HoldoffMs     = 10000;
  localparam int DrainCycles   = 2 * NumRules + 4;
  localparam int WatchdogLimit = 2000;
  localparam int RandomPhases  = 6;
  localparam int ItemsPerPhase = 56;
  localparam int TableRows     = 24;

  typedef struct packed {
    logic [1:0] rule_set;
    sample_t    smp;
    logic       typed;
    logic       typed_fires;
    alarm_t     typed_alarm;
  } vector_t;

  localparam alarm_t NoAlarm = '0;

  localparam rule_t DirectedSets [3][8] = '{
    '{default: '0},
    '{'{32'd1000, 2'd3, 8'h05, 1'b1},
      '{32'd0, 2'd1, 8'h05, 1'b1},
      '{32'hFFFF_FFFF, 2'd2, 8'hFF, 1'b1},
      '{32'd0, 2'd0, 8'h05, 1'b0},
      '{32'd2000, 2'd0, 8'h05, 1'b1},
      '{32'h8000_0000, 2'd2, 8'h00, 1'b1},
      '{32'd100, 2'd1, 8'hAA, 1'b1},
      '{32'hFFFF_FFFF, 2'd3, 8'h05, 1'b1}},
    '{'{32'd0, 2'd0, 8'h33, 1'b1},
      '{32'd0, 2'd1, 8'h33, 1'b1},
      '{32'd0, 2'd2, 8'h33, 1'b1},
      '{32'd0, 2'd3, 8'h33, 1'b1},
      '{32'd0, 2'd0, 8'h33, 1'b1},
      '{32'd0, 2'd1, 8'h33, 1'b1},
      '{32'd0, 2'd2, 8'h33, 1'b1},
      '{32'd0, 2'd3, 8'h33, 1'b1}}
  };

  // Rows with typed set carry their alarm (or the lack of one) in the table;
  // all other rows are checked against the rule walk below.
  localparam vector_t SampleTable [TableRows] = '{
    '{2'd0, '{8'h00, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF}, 1'b1, 1'b0, NoAlarm},
    '{2'd0, '{8'hFF, 32'd0, 48'd0}, 1'b1, 1'b0, NoAlarm},
    '{2'd1, '{8'hFF, 32'hFFFF_FFFF, 48'd1}, 1'b1, 1'b1,
      '{3'd2, 8'hFF, 2'd2, 48'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}},
    '{2'd1, '{8'hFF, 32'hFFFF_FFFE, 48'd2}, 1'b1, 1'b0, NoAlarm},
    '{2'd1, '{8'h05, 32'd1500, 48'd0}, 1'b0, 1'b0, NoAlarm},
    '{2'd1, '{8'h05, 32'd1500, 48'd5}, 1'b0, 1'b0, NoAlarm},
    '{2'd1, '{8'h05, 32'd1500, 48'd100}, 1'b0, 1'b0, NoAlarm},
    '{2'd1, '{8'h05, 32'd0, 48'd200}, 1'b0, 1'b0, NoAlarm},
    '{2'd1, '{8'h05, 32'd1000, 48'd10005}, 1'b0, 1'b0, NoAlarm},
    '{2'd1, '{8'h05, 32'd950, 48'd20006}, 1'b0, 1'b0, NoAlarm},
    '{2'd1, '{8'h05, 32'd899, 48'd20007}, 1'b0, 1'b0, NoAlarm},
    '{2'd1, '{8'h05, 32'd5000, 48'd3}, 1'b0, 1'b0, NoAlarm},
    '{2'd1, '{8'h05, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF}, 1'b0, 1'b0, NoAlarm},
    '{2'd1, '{8'h05, 32'hFFFF_FFFF, 48'd2}, 1'b0, 1'b0, NoAlarm},
    '{2'd1, '{8'hAA, 32'd99, 48'd30000}, 1'b1, 1'b0, NoAlarm},
    '{2'd1, '{8'hAA, 32'd100, 48'd30001}, 1'b1, 1'b1,
      '{3'd6, 8'hAA, 2'd1, 48'd30001, 32'd100, 32'd100, 1'b1}},
    '{2'd1, '{8'h00, 32'h7FFF_FFFF, 48'd40000}, 1'b1, 1'b0, NoAlarm},
    '{2'd1, '{8'h00, 32'h8000_0000, 48'd40001}, 1'b1, 1'b1,
      '{3'd5, 8'h00, 2'd2, 48'd40001, 32'h8000_0000, 32'h8000_0000, 1'b1}},
    '{2'd1, '{8'h07, 32'hFFFF_FFFF, 48'd50000}, 1'b1, 1'b0, NoAlarm},
    '{2'd2, '{8'h33, 32'd0, 48'd0}, 1'b0, 1'b0, NoAlarm},
    '{2'd2, '{8'h33, 32'hFFFF_FFFF, 48'd9999}, 1'b0, 1'b0, NoAlarm},
    '{2'd2, '{8'h33, 32'd0, 48'd19998}, 1'b0, 1'b0, NoAlarm},
    '{2'd2, '{8'h33, 32'd0, 48'd19999}, 1'b0, 1'b0, NoAlarm},
    '{2'd2, '{8'h34, 32'd0, 48'd19999}, 1'b1, 1'b0, NoAlarm}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  sample_t     in_data;
  logic        out_valid;
  logic        out_ready;
  alarm_t      out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [42:0] cfg_data;

  rule_t       rules [8];
  logic [47:0] last_fire [8];
  bit          active [8];
  alarm_t      pending_alarms [$];
  alarm_t      fresh_alarms [$];
  logic [7:0]  type_pool [3];
  logic [47:0] stamp;
  bit          calm;
  int          mismatches;
  int          samples_sent;
  int          alarms_checked;
  int          idle_cycles;

  threshold_alarm_monitor #(
    .NUM_RULES (NumRules),
    .HOLDOFF_MS(HoldoffMs)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int evaluate_rules(input sample_t smp);
    rule_t       r;
    alarm_t      hit;
    logic [47:0] elapsed;
    fresh_alarms.delete();
    for (int i = 0; i < NumRules; i++) begin
      r = rules[i];
      if (!r.valid || r.rtype != smp.metric_type) continue;
      if (smp.sample_milli >= r.threshold) begin
        elapsed = smp.now_ms - last_fire[i];
        if (last_fire[i] != '0 && elapsed < HoldoffMs) continue;
        active[i] = 1'b1;
        last_fire[i] = smp.now_ms;
        hit.rule_index     = 3'(i);
        hit.fired_type     = r.rtype;
        hit.fired_severity = r.severity;
        hit.fire_time_ms   = smp.now_ms;
        hit.value_milli    = smp.sample_milli;
        hit.limit_milli    = r.threshold;
        hit.last_alarm     = 1'b0;
        fresh_alarms.push_back(hit);
      end else if (active[i] &&
                   {4'd0, smp.sample_milli} * 36'd10 < {4'd0, r.threshold} * 36'd9) begin
        active[i] = 1'b0;
      end
    end
    if (fresh_alarms.size() > 0) fresh_alarms[fresh_alarms.size() - 1].last_alarm = 1'b1;
    return fresh_alarms.size();
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] pick_value(input logic [31:0] thr);
    logic [35:0] nine_tenths;
    case ($urandom_range(0, 4))
      0: return (thr > 32'hFFFF_FFCD) ? thr : thr + $urandom_range(0, 50);
      1: return (thr < 32'd50) ? 32'd0 : thr - $urandom_range(1, 50);
      2: begin
        nine_tenths = {4'd0, thr} * 36'd9 / 36'd10;
        return nine_tenths[31:0] + $urandom_range(0, 2) - 1;
      end
      3: return $urandom();
      default: return thr;
    endcase
  endfunction

  function automatic sample_t make_sample();
    sample_t smp;
    rule_t   r;
    int      k;
    if ($urandom_range(0, 99) < 85) begin
      r = rules[$urandom_range(0, 7)];
      smp.metric_type  = r.rtype;
      smp.sample_milli = pick_value(r.threshold);
      k = $urandom_range(0, 99);
      if (k < 65) stamp = stamp + $urandom_range(0, 2500);
      else if (k < 80) stamp = stamp + HoldoffMs - 1 + $urandom_range(0, 2);
      else if (k < 92) stamp = stamp + $urandom_range(10000, 60000);
      else if (k < 97) stamp = stamp - $urandom_range(1, 5000);
      else stamp = '0;
      smp.now_ms = stamp;
    end else begin
      smp.metric_type  = 8'($urandom_range(0, 255));
      smp.sample_milli = $urandom();
      smp.now_ms       = rand48();
    end
    return smp;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
  endtask

  task automatic check_alarm(input alarm_t got);
    alarm_t want;
    if (pending_alarms.size() == 0) begin
      report_mismatch($sformatf("alarm from rule %0d with none outstanding", got.rule_index));
      return;
    end
    want = pending_alarms.pop_front();
    alarms_checked++;
    check_field("rule_index", 64'(got.rule_index), 64'(want.rule_index));
    check_field("fired_type", 64'(got.fired_type), 64'(want.fired_type));
    check_field("fired_severity", 64'(got.fired_severity), 64'(want.fired_severity));
    check_field("fire_time_ms", 64'(got.fire_time_ms), 64'(want.fire_time_ms));
    check_field("value_milli", 64'(got.value_milli), 64'(want.value_milli));
    check_field("limit_milli", 64'(got.limit_milli), 64'(want.limit_milli));
    check_field("last_alarm", 64'(got.last_alarm), 64'(want.last_alarm));
  endtask

  task automatic send_sample(input sample_t smp);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= smp;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  task automatic drain_alarms();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_alarms.size() != 0) @(posedge clk);
  endtask

  task automatic load_rules(input rule_t words [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= words[i];
      @(posedge clk);
      rules[i] = words[i];
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int stall_left;
    int k;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_alarm(out_data);
      if (calm) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        k = $urandom_range(0, 99);
        if (k < 70) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          stall_left = (k < 96) ? $urandom_range(0, 2) : $urandom_range(15, 40);
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d alarms outstanding",
             WatchdogLimit, pending_alarms.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    vector_t row;
    sample_t smp;
    rule_t   words [8];
    int      cur_set;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    calm      = 1'b0;
    cur_set   = 0;
    for (int i = 0; i < 8; i++) begin
      rules[i]     = '0;
      last_fire[i] = '0;
      active[i]    = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int n = 0; n < TableRows; n++) begin
      row = SampleTable[n];
      if (row.rule_set != cur_set) begin
        drain_alarms();
        repeat (DrainCycles) @(posedge clk);
        load_rules(DirectedSets[row.rule_set]);
        cur_set = row.rule_set;
      end
      send_sample(row.smp);
      void'(evaluate_rules(row.smp));
      if (row.typed) begin
        if (row.typed_fires) pending_alarms.push_back(row.typed_alarm);
      end else begin
        foreach (fresh_alarms[j]) pending_alarms.push_back(fresh_alarms[j]);
      end
    end

    for (int ph = 0; ph < RandomPhases; ph++) begin
      drain_alarms();
      repeat (DrainCycles) @(posedge clk);
      calm = (ph % 3 == 2);
      for (int t = 0; t < 3; t++) type_pool[t] = (ph == 0) ? 8'hFF : 8'($urandom_range(0, 255));
      for (int i = 0; i < 8; i++) begin
        if (ph == 0) begin
          words[i] = '1;
        end else begin
          words[i].valid    = ($urandom_range(0, 7) != 0);
          words[i].rtype    = type_pool[$urandom_range(0, 2)];
          words[i].severity = 2'($urandom_range(0, 3));
          case ($urandom_range(0, 9))
            0: words[i].threshold = '0;
            1: words[i].threshold = '1;
            2, 3: words[i].threshold = $urandom();
            default: words[i].threshold = $urandom_range(0, 5000);
          endcase
        end
      end
      load_rules(words);
      stamp = (ph % 2 == 0) ? rand48() : 48'hFFFF_FFFF_F000;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (n == ItemsPerPhase / 2 && ph % 2 == 0) drain_alarms();
        smp = make_sample();
        send_sample(smp);
        void'(evaluate_rules(smp));
        foreach (fresh_alarms[j]) pending_alarms.push_back(fresh_alarms[j]);
      end
    end

    drain_alarms();
    repeat (DrainCycles) @(posedge clk);
    $display("summary: %0d samples sent, %0d alarms checked, %0d mismatches",
             samples_sent, alarms_checked, mismatches);
    $display("summary: %0d directed rows and %0d random phases of rule settings",
             TableRows, RandomPhases);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/tam_pkg.sv
design/tam_front.sv
design/tam_queue.sv
design/tam_back.sv
design/threshold_alarm_monitor.sv
test/threshold_alarm_monitor_tb.sv
